### hdl/sysex_seven_bit_packetizer_assert.svh
// Assertion macros for the SysEx seven-bit packetizer
`ifndef SYSEX_SEVEN_BIT_PACKETIZER_ASSERT_SVH
`define SYSEX_SEVEN_BIT_PACKETIZER_ASSERT_SVH

// check cons in the same cycle as ante
`define SX7_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SX7_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sysex7_pkg.sv
// Types, constants and helpers shared by the SysEx seven-bit packetizer
package sysex7_pkg;

  localparam logic [7:0] START_BYTE = 8'hF0;
  localparam logic [7:0] END_BYTE   = 8'hF7;
  localparam logic [3:0] CODE_CONT  = 4'h4;
  localparam logic [3:0] CODE_END1  = 4'h5;
  localparam logic [3:0] CODE_END2  = 4'h6;
  localparam logic [3:0] CODE_END3  = 4'h7;
  localparam logic [6:0] SEVEN_MASK = 7'h7F;

  localparam logic [2:0] MAX_LEFT = 3'd6;
  localparam logic [1:0] MAX_HELD = 2'd2;

  typedef struct packed {
    logic       inm;
    logic [5:0] lb;
    logic [2:0] lc;
    logic [1:0] hc;
    logic [7:0] h0;
    logic [7:0] h1;
  } st_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic       last;
  } pkt_t;

  typedef struct packed {
    logic [1:0] np;
    pkt_t       p0;
    pkt_t       p1;
  } core_res_t;

  function automatic logic [3:0] end_code(input logic [2:0] rem);
    logic [3:0] c;
    case (rem)
      3'd1:    c = CODE_END1;
      3'd2:    c = CODE_END2;
      default: c = CODE_END3;
    endcase
    return c;
  endfunction

  function automatic pkt_t mk_pkt(input logic [3:0] cable, input logic [3:0] code,
                                  input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic lst);
    pkt_t p;
    p.header = {cable, code};
    p.d0     = b0;
    p.d1     = b1;
    p.d2     = b2;
    p.last   = lst;
    return p;
  endfunction

endpackage

### hdl/sysex7_core.sv
// Single-pass regrouping, framing and packet cutting for one payload byte
module sysex7_core (
  input  sysex7_pkg::st_t       st_i,
  input  logic [7:0]            pay_i,
  input  logic                  last_i,
  input  logic [3:0]            cable_i,
  output sysex7_pkg::st_t       st_o,
  output sysex7_pkg::core_res_t res_o
);

  logic [2:0]  bits;
  logic [5:0]  omask;
  logic [13:0] acc;
  logic        two_grp;
  logic [2:0]  rb;
  logic [5:0]  rmask;
  logic [5:0]  lb_n;
  logic [6:0]  g0;
  logic [6:0]  g1;
  logic [6:0]  pad;
  logic [2:0]  hcl;
  logic [7:0]  seq [8];
  logic [2:0]  n;

  always_comb begin
    bits    = (st_i.lc > sysex7_pkg::MAX_LEFT) ? sysex7_pkg::MAX_LEFT : st_i.lc;
    omask   = 6'((7'd1 << bits) - 7'd1);
    acc     = {st_i.lb & omask, pay_i};
    two_grp = (bits == sysex7_pkg::MAX_LEFT);
    if (two_grp) begin
      g0 = acc[13:7];
      g1 = acc[6:0];
      rb = 3'd0;
    end else begin
      g0 = 7'(acc >> (bits + 3'd1)) & sysex7_pkg::SEVEN_MASK;
      g1 = 7'd0;
      rb = bits + 3'd1;
    end
    rmask = 6'((7'd1 << rb) - 7'd1);
    lb_n  = pay_i[5:0] & rmask;
    pad   = 7'({1'b0, lb_n} << (3'd7 - rb)) & sysex7_pkg::SEVEN_MASK;
  end

  // build the framed byte sequence
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      seq[i] = 8'd0;
    end
    n   = 3'd0;
    hcl = (st_i.hc > sysex7_pkg::MAX_HELD) ? {1'b0, sysex7_pkg::MAX_HELD} : {1'b0, st_i.hc};
    if (hcl >= 3'd1) begin
      seq[n] = st_i.h0;
      n      = n + 3'd1;
    end
    if (hcl >= 3'd2) begin
      seq[n] = st_i.h1;
      n      = n + 3'd1;
    end
    if (!st_i.inm) begin
      seq[n] = sysex7_pkg::START_BYTE;
      n      = n + 3'd1;
    end
    seq[n] = {1'b0, g0};
    n      = n + 3'd1;
    if (two_grp) begin
      seq[n] = {1'b0, g1};
      n      = n + 3'd1;
    end
    if (last_i) begin
      if (rb != 3'd0) begin
        seq[n] = {1'b0, pad};
        n      = n + 3'd1;
      end
      seq[n] = sysex7_pkg::END_BYTE;
      n      = n + 3'd1;
    end
  end

  // cut packets and advance state
  always_comb begin
    res_o.np = 2'd0;
    res_o.p0 = '0;
    res_o.p1 = '0;
    st_o     = st_i;
    if (last_i) begin
      if (n <= 3'd3) begin
        res_o.np = 2'd1;
        res_o.p0 = sysex7_pkg::mk_pkt(cable_i, sysex7_pkg::end_code(n),
                                      seq[0], seq[1], seq[2], 1'b1);
      end else begin
        res_o.np = 2'd2;
        res_o.p0 = sysex7_pkg::mk_pkt(cable_i, sysex7_pkg::CODE_CONT,
                                      seq[0], seq[1], seq[2], 1'b0);
        res_o.p1 = sysex7_pkg::mk_pkt(cable_i, sysex7_pkg::end_code(n - 3'd3),
                                      seq[3], seq[4], seq[5], 1'b1);
      end
      st_o.inm = 1'b0;
      st_o.lb  = 6'd0;
      st_o.lc  = 3'd0;
      st_o.hc  = 2'd0;
    end else begin
      if (n >= 3'd3) begin
        res_o.np = 2'd1;
        res_o.p0 = sysex7_pkg::mk_pkt(cable_i, sysex7_pkg::CODE_CONT,
                                      seq[0], seq[1], seq[2], 1'b1);
        st_o.hc  = 2'(n - 3'd3);
        st_o.h0  = seq[3];
        st_o.h1  = seq[4];
      end else begin
        st_o.hc = n[1:0];
        st_o.h0 = seq[0];
        st_o.h1 = seq[1];
      end
      st_o.inm = 1'b1;
      st_o.lb  = lb_n;
      st_o.lc  = two_grp ? 3'd0 : rb;
    end
  end

endmodule

### hdl/sysex7_pkt_queue.sv
// Two-entry result queue for USB-MIDI event packets
module sysex7_pkt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [1:0]        np_i,
  input  sysex7_pkg::pkt_t  p0_i,
  input  sysex7_pkg::pkt_t  p1_i,
  input  logic              ready_i,
  output logic              valid_o,
  output sysex7_pkg::pkt_t  head_o,
  output logic [1:0]        free_o
);

  logic [1:0]       cnt_r, cnt_nxt;
  sysex7_pkg::pkt_t slot0_r, slot0_nxt;
  sysex7_pkg::pkt_t slot1_r, slot1_nxt;
  logic             pop;
  logic [1:0]       cnt_p;

  assign valid_o = (cnt_r != 2'd0);
  assign head_o  = slot0_r;
  assign pop     = valid_o && ready_i;
  assign cnt_p   = cnt_r - {1'b0, pop};
  assign free_o  = 2'd2 - cnt_p;

  always_comb begin
    cnt_nxt   = cnt_p;
    slot0_nxt = pop ? slot1_r : slot0_r;
    slot1_nxt = slot1_r;
    if (push_i) begin
      case (cnt_p)
        2'd0: begin
          slot0_nxt = p0_i;
          slot1_nxt = p1_i;
          cnt_nxt   = np_i;
        end
        2'd1: begin
          slot1_nxt = p0_i;
          cnt_nxt   = 2'd1 + np_i;
        end
        default: begin
          cnt_nxt = cnt_p;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

### hdl/sysex7_cfg.sv
// APB register bank holding the cable number
module sysex7_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  cable_o
);

  logic [3:0] cable_r, cable_nxt;
  logic       wr;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign cable_o = cable_r;
  assign prdata  = (paddr[2] == 1'b0) ? {28'd0, cable_r} : 32'd0;

  always_comb begin
    cable_nxt = cable_r;
    if (wr && (paddr[2] == 1'b0)) begin
      cable_nxt = pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cable_r <= 4'd0;
    end else begin
      cable_r <= cable_nxt;
    end
  end

endmodule

### hdl/sysex_seven_bit_packetizer.sv
// Top level of the SysEx seven-bit packetizer
//
//   channel  direction  tdata                                  tlast
//   in_      slave      [7:0] payload_byte                     last_byte
//   out_     master     [7:0] packet_header, [15:8] data_first, last_of_run
//                       [23:16] data_second, [31:24] data_third
//   cfg_     APB        register 0 at byte address 0: cable_id [3:0]
//
// An item is held in the input register, then moves through the combinational packet
// logic into a two-entry result queue.
// A byte yields no packet or one packet; a closing byte may yield two packets,
// each sent as its own output transfer.
// The input register stalls while the queue lacks room for the item's packets.
// Synchronous active-low reset empties both stages; no clearing pass.
`include "sysex_seven_bit_packetizer_assert.svh"

module sysex_seven_bit_packetizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] header, [15:8] first, [23:16] second, [31:24] third
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                  a_valid_r, a_valid_nxt;
  logic [7:0]            a_pay_r;
  logic                  a_last_r;
  logic                  a_move;
  logic                  in_acc;
  sysex7_pkg::st_t       st_r, st_nxt;
  sysex7_pkg::core_res_t res;
  sysex7_pkg::pkt_t      head;
  logic [1:0]            q_free;
  logic [3:0]            cable;

  sysex7_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cable_o (cable)
  );

  sysex7_core u_core (
    .st_i    (st_r),
    .pay_i   (a_pay_r),
    .last_i  (a_last_r),
    .cable_i (cable),
    .st_o    (st_nxt),
    .res_o   (res)
  );

  sysex7_pkt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (a_move),
    .np_i    (res.np),
    .p0_i    (res.p0),
    .p1_i    (res.p1),
    .ready_i (out_tready),
    .valid_o (out_tvalid),
    .head_o  (head),
    .free_o  (q_free)
  );

  assign a_move    = a_valid_r && (res.np <= q_free);
  assign in_tready = !a_valid_r || a_move;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tdata = {head.d2, head.d1, head.d0, head.header};
  assign out_tlast = head.last;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pay_r  <= in_tdata;
      a_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.inm <= 1'b0;
      st_r.lb  <= 6'd0;
      st_r.lc  <= 3'd0;
      st_r.hc  <= 2'd0;
    end else if (a_move) begin
      st_r <= st_nxt;
    end
  end

  `SX7_ASSERT_NEXT(a_end_clears, a_move && a_last_r, (st_r.inm == 1'b0) && (st_r.lc == 3'd0) && (st_r.hc == 2'd0), "state not cleared after closing item")
  `SX7_ASSERT_SAME(a_state_range, 1'b1, (st_r.hc != 2'd3) && (st_r.lc <= 3'd6), "held or leftover count out of range")
  `SX7_ASSERT_SAME(a_close_emits, a_move && a_last_r, res.np != 2'd0, "closing item produced no packet")
  `SX7_ASSERT_SAME(a_mid_single, a_move && !a_last_r, res.np <= 2'd1, "mid-message item produced two packets")

endmodule

### tb/sv/tb_sysex_seven_bit_packetizer.sv
// Testbench for the SysEx seven-bit packetizer: directed and random messages checked against a packet predictor
module tb_sysex_seven_bit_packetizer;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          RANDOM_ITEMS  = 1950;
  localparam int          SETTLE_CYCLES = 6;
  localparam logic [2:0]  ADDR_CABLE    = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED   = 3'd4;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;  // [7:0] payload_byte
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;            // [7:0] header, [15:8] first, [23:16] second, [31:24] third
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = 3'd0;
  logic [31:0] cfg_pwdata  = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  logic [3:0]  cur_cable  = 4'd0;
  logic        msg_open   = 1'b0;
  logic [5:0]  spare_bits = 6'd0;
  int          spare_cnt  = 0;
  logic [7:0]  held_byte [0:1];
  int          held_cnt   = 0;

  sysex7_pkg::pkt_t expected_packets [$];
  sysex7_pkg::pkt_t want;
  int          err_count   = 0;
  int          sent_items  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          gaps_on     = 1'b1;

  sysex_seven_bit_packetizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic void push_packet(input logic [3:0] code, input logic [7:0] b0,
                                      input logic [7:0] b1, input logic [7:0] b2,
                                      input logic fin);
    sysex7_pkg::pkt_t p;
    p.header = {cur_cable, code};
    p.d0     = b0;
    p.d1     = b1;
    p.d2     = b2;
    p.last   = fin;
    expected_packets.push_back(p);
  endfunction

  function automatic void predict_packets(input logic [7:0] pay, input logic fin);
    logic [7:0]  seq [0:7];
    logic [15:0] acc;
    logic [15:0] padded;
    logic [3:0]  code;
    int          n;
    int          pos;
    int          nbits;
    int          rem;
    int          emitted;
    n       = 0;
    pos     = 0;
    emitted = 0;
    for (int i = 0; i < held_cnt; i++) begin
      seq[n] = held_byte[i];
      n++;
    end
    if (!msg_open) begin
      seq[n] = sysex7_pkg::START_BYTE;
      n++;
    end
    acc   = {2'b00, spare_bits, pay};
    nbits = spare_cnt + 8;
    while (nbits >= 7) begin
      seq[n] = {1'b0, acc[nbits-1 -: 7]};
      n++;
      nbits -= 7;
    end
    acc = acc & ((16'd1 << nbits) - 16'd1);
    if (fin) begin
      if (nbits > 0) begin
        padded = acc << (7 - nbits);
        seq[n] = {1'b0, padded[6:0]};
        n++;
      end
      seq[n] = sysex7_pkg::END_BYTE;
      n++;
      while (n - pos > 3) begin
        push_packet(sysex7_pkg::CODE_CONT, seq[pos], seq[pos+1], seq[pos+2], 1'b0);
        pos += 3;
      end
      rem  = n - pos;
      code = (rem == 1) ? sysex7_pkg::CODE_END1 :
             (rem == 2) ? sysex7_pkg::CODE_END2 : sysex7_pkg::CODE_END3;
      push_packet(code, seq[pos], (rem > 1) ? seq[pos+1] : 8'h00,
                  (rem > 2) ? seq[pos+2] : 8'h00, 1'b1);
      msg_open   = 1'b0;
      spare_bits = 6'd0;
      spare_cnt  = 0;
      held_cnt   = 0;
    end else begin
      while (n - pos >= 3) begin
        push_packet(sysex7_pkg::CODE_CONT, seq[pos], seq[pos+1], seq[pos+2], 1'b0);
        pos += 3;
        emitted++;
      end
      if (emitted > 0) expected_packets[expected_packets.size()-1].last = 1'b1;
      held_cnt = n - pos;
      for (int i = 0; i < held_cnt; i++) held_byte[i] = seq[pos+i];
      msg_open   = 1'b1;
      spare_bits = acc[5:0];
      spare_cnt  = nbits;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    err_count++;
    if (err_count <= 40)
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, exp_val,
               cycle_count);
  endtask

  // packet checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_packets.size() == 0) begin
        report_mismatch("packet with none expected", out_tdata, 32'h0);
      end else begin
        want = expected_packets.pop_front();
        if (out_tdata[7:0] != want.header)
          report_mismatch("packet_header", 32'(out_tdata[7:0]), 32'(want.header));
        if (out_tdata[15:8] != want.d0)
          report_mismatch("data_first", 32'(out_tdata[15:8]), 32'(want.d0));
        if (out_tdata[23:16] != want.d1)
          report_mismatch("data_second", 32'(out_tdata[23:16]), 32'(want.d1));
        if (out_tdata[31:24] != want.d2)
          report_mismatch("data_third", 32'(out_tdata[31:24]), 32'(want.d2));
        if (out_tlast != want.last)
          report_mismatch("last_of_run", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [7:0] pay, input logic fin);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pay;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    predict_packets(pay, fin);
    sent_items++;
  endtask

  function automatic logic [7:0] random_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_message(input int len, input bit close);
    for (int k = 0; k < len; k++) send_item(random_payload(), close && (k == len - 1));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_CABLE) cur_cable = value[3:0];
    @(posedge clk);
  endtask

  task automatic check_cable_readback();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_CABLE;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[3:0] != cur_cable)
      report_mismatch("cable readback", cfg_prdata, 32'(cur_cable));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_frame_lengths();
    gaps_on = 1'b1;
    check_cable_readback();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h80, 1'b1);
    // seven bytes fill whole groups, no padding
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(8'hC3, 1'b1);
    wait_idle();
  endtask

  task automatic test_register_access();
    cfg_write(ADDR_CABLE, 32'h0000_000F);
    check_cable_readback();
    cfg_write(ADDR_UNUSED, 32'h0000_0005);
    check_cable_readback();
    send_item(8'hA5, 1'b1);
    wait_idle();
    cfg_write(ADDR_CABLE, 32'hFFFF_FFF3);
    check_cable_readback();
  endtask

  task automatic test_cable_change_mid_message();
    gaps_on = 1'b0;
    send_item(8'h3C, 1'b0);
    send_item(8'hE1, 1'b0);
    wait_idle();
    cfg_write(ADDR_CABLE, 32'h0000_0009);
    send_item(8'h96, 1'b0);
    send_item(8'h0F, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_messages();
    int start_items;
    int msg_idx;
    int len;
    int r;
    int cut;
    start_items = sent_items;
    msg_idx     = 0;
    while (sent_items - start_items < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 99) < 80);
      if (msg_idx % 25 == 24) begin
        wait_idle();
        r = $urandom_range(0, 3);
        if (r == 0) cfg_write(ADDR_CABLE, 32'h0);
        else if (r == 1) cfg_write(ADDR_CABLE, 32'hF);
        else cfg_write(ADDR_CABLE, $urandom);
        if ($urandom_range(0, 1) == 0) cfg_write(ADDR_UNUSED, $urandom);
        check_cable_readback();
      end
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 10);
      else if (r < 97) len = $urandom_range(11, 40);
      else len = $urandom_range(41, 100);
      if (len > 1 && (msg_idx == 10 || $urandom_range(0, 49) == 0)) begin
        // hold mid-message until the block drains, then sometimes retune the cable
        cut = $urandom_range(1, len - 1);
        send_message(cut, 1'b0);
        wait_idle();
        if ($urandom_range(0, 1) == 0) cfg_write(ADDR_CABLE, $urandom);
        send_message(len - cut, 1'b1);
      end else begin
        send_message(len, 1'b1);
      end
      msg_idx++;
    end
  endtask

  initial begin
    held_byte[0] = 8'h00;
    held_byte[1] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_lengths();
    test_register_access();
    test_cable_change_mid_message();
    test_random_messages();
    in_tvalid <= 1'b0;
    while (expected_packets.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/sysex7_pkg.sv
hdl/sysex7_core.sv
hdl/sysex7_pkt_queue.sv
hdl/sysex7_cfg.sv
hdl/sysex_seven_bit_packetizer.sv
tb/sv/tb_sysex_seven_bit_packetizer.sv
